// ===== hw/rtl/key_matrix_ghost_resolver_defines.svh =====
// ----------------------------------------------------------------------------
// key matrix ghost resolver assertion macros
// shared helpers for the concurrent checks of the resolver
// ----------------------------------------------------------------------------
`ifndef KEY_MATRIX_GHOST_RESOLVER_DEFINES_SVH
`define KEY_MATRIX_GHOST_RESOLVER_DEFINES_SVH

// consequent must hold in the cycle after the antecedent
`define KMGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kmgr check failed: next-cycle property");

// consequent must hold in the same cycle as the antecedent
`define KMGR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kmgr check failed: same-cycle property");

`endif

// ===== hw/rtl/kmgr_pkg.sv =====
// ----------------------------------------------------------------------------
// kmgr_pkg
// shared sizes, request codes and control structs of the ghost resolver
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kmgr_pkg;

  // matrix geometry
  localparam int NUM_COLS  = 8;
  localparam int NUM_ROWS  = 7;
  localparam int COL_IDX_W = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
  localparam int ROW_IDX_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

  // word field widths
  localparam int REQ_TYPE_W  = 2;
  localparam int KEY_COL_W   = 3;
  localparam int KEY_ROW_W   = 3;
  localparam int COL_FIELD_W = 8;
  localparam int ROW_FIELD_W = 7;

  // request codes
  localparam logic [REQ_TYPE_W-1:0] REQ_PRESS   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_RELEASE = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_READ    = 2'd2;

  typedef logic [NUM_COLS-1:0] col_mask_t;
  typedef logic [NUM_ROWS-1:0] row_mask_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture read masks
    logic key_wr;     // update one key
    logic key_set;    // press when set, release when clear
    logic col_pass;   // one column merge sweep
    logic row_pass;   // one row merge sweep
    logic sink_col;   // direct connections, column side
    logic sink_row;   // direct connections, row side
    logic out_load;   // move result into output register
  } kmgr_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rs_changed; // column sweep altered row sinks
    logic cs_changed; // row sweep altered column sinks
    logic out_free;   // output register can take a word
  } kmgr_sts_t;

endpackage

// ===== hw/rtl/kmgr_req_if.sv =====
// ----------------------------------------------------------------------------
// kmgr_req_if
// request channel: press, release and read words
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kmgr_req_if;
  logic                               valid;
  logic                               ready;
  logic [kmgr_pkg::REQ_TYPE_W-1:0]    req_type;
  logic [kmgr_pkg::KEY_COL_W-1:0]     key_col;
  logic [kmgr_pkg::KEY_ROW_W-1:0]     key_row;
  logic [kmgr_pkg::COL_FIELD_W-1:0]   col_sink_in;
  logic [kmgr_pkg::ROW_FIELD_W-1:0]   row_sink_in;
  logic [kmgr_pkg::COL_FIELD_W-1:0]   col_source_in;
  logic [kmgr_pkg::ROW_FIELD_W-1:0]   row_source_in;

  modport source (
    output valid, req_type, key_col, key_row,
           col_sink_in, row_sink_in, col_source_in, row_source_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, key_col, key_row,
           col_sink_in, row_sink_in, col_source_in, row_source_in,
    output ready
  );
endinterface

// ===== hw/rtl/kmgr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// kmgr_rsp_if
// response channel: resolved sink and source masks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kmgr_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [kmgr_pkg::COL_FIELD_W-1:0]   col_sink_out;
  logic [kmgr_pkg::ROW_FIELD_W-1:0]   row_sink_out;
  logic [kmgr_pkg::COL_FIELD_W-1:0]   col_source_out;
  logic [kmgr_pkg::ROW_FIELD_W-1:0]   row_source_out;

  modport source (
    output valid, col_sink_out, row_sink_out, col_source_out, row_source_out,
    input  ready
  );

  modport sink (
    input  valid, col_sink_out, row_sink_out, col_source_out, row_source_out,
    output ready
  );
endinterface

// ===== hw/rtl/kmgr_dpath.sv =====
// ----------------------------------------------------------------------------
// kmgr_dpath
// pressed-key store, working masks, merge sweeps and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmgr_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  kmgr_pkg::kmgr_cmd_t                  cmd,
  output kmgr_pkg::kmgr_sts_t                  sts,
  input  logic [kmgr_pkg::KEY_COL_W-1:0]       key_col,
  input  logic [kmgr_pkg::KEY_ROW_W-1:0]       key_row,
  input  logic [kmgr_pkg::COL_FIELD_W-1:0]     col_sink_in,
  input  logic [kmgr_pkg::ROW_FIELD_W-1:0]     row_sink_in,
  input  logic [kmgr_pkg::COL_FIELD_W-1:0]     col_source_in,
  input  logic [kmgr_pkg::ROW_FIELD_W-1:0]     row_source_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [kmgr_pkg::COL_FIELD_W-1:0]     col_sink_out,
  output logic [kmgr_pkg::ROW_FIELD_W-1:0]     row_sink_out,
  output logic [kmgr_pkg::COL_FIELD_W-1:0]     col_source_out,
  output logic [kmgr_pkg::ROW_FIELD_W-1:0]     row_source_out
);
  import kmgr_pkg::*;

  // pressed keys, one row mask per column
  row_mask_t pressed [NUM_COLS];
  // the same keys seen from the rows, one column mask per row
  col_mask_t row_keys [NUM_ROWS];

  // working masks
  col_mask_t cs;
  row_mask_t rs;
  col_mask_t csrc;
  row_mask_t rsrc;

  col_mask_t cs_next;
  row_mask_t rs_next;
  col_mask_t csrc_next;
  row_mask_t rsrc_next;

  // results of the four sweep kinds
  col_mask_t colp_cs;
  row_mask_t colp_rs;
  col_mask_t rowp_cs;
  row_mask_t rowp_rs;
  row_mask_t snkc_rs;
  row_mask_t snkc_rsrc;
  col_mask_t snkr_cs;
  col_mask_t snkr_csrc;

  logic key_hit;

  // key address in range of the matrix
  assign key_hit = (32'(key_col) < NUM_COLS) && (32'(key_row) < NUM_ROWS);

  // pressed-key store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        pressed[c] <= '0;
      end
    end else if (cmd.key_wr && key_hit) begin
      pressed[COL_IDX_W'(key_col)][ROW_IDX_W'(key_row)] <= cmd.key_set;
    end
  end

  // transpose of the store
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        row_keys[r][c] = pressed[c][r];
      end
    end
  end

  // column merge sweep, columns in ascending order
  always_comb begin
    colp_cs = cs;
    colp_rs = rs;
    for (int i = 0; i < NUM_COLS; i++) begin
      if ((~colp_rs & pressed[i]) != '0) begin
        colp_cs[i] = 1'b0;
        colp_rs    = colp_rs & ~pressed[i];
      end
    end
  end

  // row merge sweep, rows in ascending order
  always_comb begin
    rowp_cs = cs;
    rowp_rs = rs;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if ((~rowp_cs & row_keys[i]) != '0) begin
        rowp_rs[i] = 1'b0;
        rowp_cs    = rowp_cs & ~row_keys[i];
      end
    end
  end

  // direct connections from sunk or sourced columns
  always_comb begin
    snkc_rs   = rs;
    snkc_rsrc = rsrc;
    for (int i = 0; i < NUM_COLS; i++) begin
      if (!cs[i]) begin
        snkc_rs = snkc_rs & ~pressed[i];
      end
      if (csrc[i]) begin
        snkc_rsrc = snkc_rsrc | pressed[i];
      end
    end
  end

  // direct connections from sunk or sourced rows
  always_comb begin
    snkr_cs   = cs;
    snkr_csrc = csrc;
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (!rs[i]) begin
        snkr_cs = snkr_cs & ~row_keys[i];
      end
      if (rsrc[i]) begin
        snkr_csrc = snkr_csrc | row_keys[i];
      end
    end
  end

  // working mask update
  always_comb begin
    cs_next   = cs;
    rs_next   = rs;
    csrc_next = csrc;
    rsrc_next = rsrc;
    if (cmd.load) begin
      cs_next   = NUM_COLS'(col_sink_in);
      rs_next   = NUM_ROWS'(row_sink_in);
      csrc_next = NUM_COLS'(col_source_in);
      rsrc_next = NUM_ROWS'(row_source_in);
    end else if (cmd.col_pass) begin
      cs_next = colp_cs;
      rs_next = colp_rs;
    end else if (cmd.row_pass) begin
      cs_next = rowp_cs;
      rs_next = rowp_rs;
    end else if (cmd.sink_col) begin
      rs_next   = snkc_rs;
      rsrc_next = snkc_rsrc;
    end else if (cmd.sink_row) begin
      cs_next   = snkr_cs;
      csrc_next = snkr_csrc;
    end
  end

  always_ff @(posedge clk) begin
    cs   <= cs_next;
    rs   <= rs_next;
    csrc <= csrc_next;
    rsrc <= rsrc_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      col_sink_out   <= COL_FIELD_W'(cs);
      row_sink_out   <= ROW_FIELD_W'(rs);
      col_source_out <= COL_FIELD_W'(csrc);
      row_source_out <= ROW_FIELD_W'(rsrc);
    end
  end

  // status back to the controller
  assign sts.rs_changed = (colp_rs != rs);
  assign sts.cs_changed = (rowp_cs != cs);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

// ===== hw/rtl/kmgr_ctrl.sv =====
// ----------------------------------------------------------------------------
// kmgr_ctrl
// sequencer for key updates and the merge and sink passes of a read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kmgr_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kmgr_pkg::REQ_TYPE_W-1:0]   req_type,
  input  kmgr_pkg::kmgr_sts_t               sts,
  output kmgr_pkg::kmgr_cmd_t               cmd
);
  import kmgr_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_COLM = 3'd1;
  localparam logic [2:0] ST_ROWM = 3'd2;
  localparam logic [2:0] ST_SNKC = 3'd3;
  localparam logic [2:0] ST_SNKR = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type)
            REQ_PRESS: begin
              cmd.key_wr  = 1'b1;
              cmd.key_set = 1'b1;
            end
            REQ_RELEASE: begin
              cmd.key_wr = 1'b1;
            end
            REQ_READ: begin
              cmd.load   = 1'b1;
              state_next = ST_COLM;
            end
            default: ;
          endcase
        end
      end
      // repeat column sweeps until the row sinks settle
      ST_COLM: begin
        cmd.col_pass = 1'b1;
        if (!sts.rs_changed) begin
          state_next = ST_ROWM;
        end
      end
      // repeat row sweeps until the column sinks settle
      ST_ROWM: begin
        cmd.row_pass = 1'b1;
        if (!sts.cs_changed) begin
          state_next = ST_SNKC;
        end
      end
      ST_SNKC: begin
        cmd.sink_col = 1'b1;
        state_next   = ST_SNKR;
      end
      ST_SNKR: begin
        cmd.sink_row = 1'b1;
        state_next   = ST_OUT;
      end
      // wait for room in the output register
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hw/rtl/key_matrix_ghost_resolver.sv =====
// ----------------------------------------------------------------------------
// key_matrix_ghost_resolver
// key matrix with ghosting: stores pressed keys and resolves line masks
// ----------------------------------------------------------------------------
// Press and release words give no response. A read word passes through
// these steps before its response is in the output register: the accepting
// cycle captures the masks, then column merge sweeps repeat until the row
// sinks settle, row merge sweeps repeat until the column sinks settle, the
// direct sink and source step runs on the column side and then the row side,
// and the output register is loaded. The load waits while an earlier
// response is still unread. The sweep counts depend on how far
// ghosting spreads across the pressed keys; each sweep visits every line of
// one side in a cycle. The request side is held off while a read is being
// resolved; a finished response may wait in the output register while new
// words are taken.
`timescale 1ns / 1ps

module key_matrix_ghost_resolver (
  input  logic        clk,
  input  logic        rst,
  kmgr_req_if.sink    req,
  kmgr_rsp_if.source  rsp
);
  import kmgr_pkg::*;

  kmgr_cmd_t cmd;
  kmgr_sts_t sts;

  // sequencer
  kmgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .req_type (req.req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  // key store and mask datapath
  kmgr_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .key_col        (req.key_col),
    .key_row        (req.key_row),
    .col_sink_in    (req.col_sink_in),
    .row_sink_in    (req.row_sink_in),
    .col_source_in  (req.col_source_in),
    .row_source_in  (req.row_source_in),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .col_sink_out   (rsp.col_sink_out),
    .row_sink_out   (rsp.row_sink_out),
    .col_source_out (rsp.col_source_out),
    .row_source_out (rsp.row_source_out)
  );

endmodule

// ===== hw/rtl/kmgr_checker.sv =====
// ----------------------------------------------------------------------------
// kmgr_checker
// port-level checks of the ghost resolver, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_matrix_ghost_resolver_defines.svh"

module kmgr_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [kmgr_pkg::REQ_TYPE_W-1:0]   in_req_type,
  input logic                              out_valid,
  input logic                              out_ready
);
  import kmgr_pkg::*;

  logic key_take;
  logic read_take;

  // accepted words, split by kind
  assign key_take  = in_valid && in_ready && (in_req_type != REQ_READ);
  assign read_take = in_valid && in_ready && (in_req_type == REQ_READ);

  // a waiting response stays offered until taken
  `KMGR_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)

  // a key update or unused code never produces a response
  `KMGR_ASSERT_NEXT(a_no_rsp_for_key, clk, rst, key_take && !out_valid, !out_valid)

  // a read holds off the request side while it is resolved
  `KMGR_ASSERT_NEXT(a_read_busy, clk, rst, read_take, !in_ready)

  // a new response appears just as the block returns to taking words
  `KMGR_ASSERT_NOW(a_rsp_then_idle, clk, rst, $rose(out_valid), in_ready)

endmodule

bind key_matrix_ghost_resolver kmgr_checker u_kmgr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .in_req_type (req.req_type),
  .out_valid   (rsp.valid),
  .out_ready   (rsp.ready)
);

// ===== sim/key_matrix_ghost_resolver_checker.sv =====
// ----------------------------------------------------------------------------
// key matrix ghost resolver checker
// watches both channels, keeps its own copy of the pressed keys, works out
// the resolved masks of every accepted read and compares each response word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_ghost_resolver_checker
  import kmgr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  kmgr_req_if   req,
  kmgr_rsp_if   rsp,
  output int    mismatches,
  output int    pending
);

  typedef struct packed {
    logic [COL_FIELD_W-1:0] cs_mask;
    logic [ROW_FIELD_W-1:0] rs_mask;
    logic [COL_FIELD_W-1:0] csrc_mask;
    logic [ROW_FIELD_W-1:0] rsrc_mask;
  } line_masks_t;

  // one bit per pressed key, indexed by column
  row_mask_t   key_down [NUM_COLS];
  line_masks_t resolved_q [$];

  // ghosting resolution of one read against the current key state
  function automatic line_masks_t resolve_lines(
    input logic [COL_FIELD_W-1:0] cs_in,
    input logic [ROW_FIELD_W-1:0] rs_in,
    input logic [COL_FIELD_W-1:0] csrc_in,
    input logic [ROW_FIELD_W-1:0] rsrc_in
  );
    col_mask_t   cs, csrc, prev_cs;
    row_mask_t   rs, rsrc, prev_rs;
    row_mask_t   col_open [NUM_COLS];
    col_mask_t   row_open [NUM_ROWS];
    line_masks_t res;
    cs   = cs_in[NUM_COLS-1:0];
    rs   = rs_in[NUM_ROWS-1:0];
    csrc = csrc_in[NUM_COLS-1:0];
    rsrc = rsrc_in[NUM_ROWS-1:0];

    // active-low views of the pressed keys, per column and per row
    for (int c = 0; c < NUM_COLS; c++) col_open[c] = ~key_down[c];
    for (int r = 0; r < NUM_ROWS; r++) begin
      row_open[r] = '1;
      for (int c = 0; c < NUM_COLS; c++)
        if (key_down[c][r]) row_open[r][c] = 1'b0;
    end

    // columns sharing sunk rows merge until the row sinks settle
    do begin
      prev_rs = rs;
      for (int c = 0; c < NUM_COLS; c++) begin
        if (((~rs) & (~col_open[c])) != '0) begin
          cs[c] = 1'b0;
          rs &= col_open[c];
        end
      end
    end while (prev_rs != rs);

    // rows sharing sunk columns merge until the column sinks settle
    do begin
      prev_cs = cs;
      for (int r = 0; r < NUM_ROWS; r++) begin
        if (((~cs) & (~row_open[r])) != '0) begin
          rs[r] = 1'b0;
          cs &= row_open[r];
        end
      end
    end while (prev_cs != cs);

    // direct connections, column side then row side
    for (int c = 0; c < NUM_COLS; c++) begin
      if (!cs[c]) rs &= col_open[c];
      if (csrc[c]) rsrc |= ~col_open[c];
    end
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (!rs[r]) cs &= row_open[r];
      if (rsrc[r]) csrc |= ~row_open[r];
    end

    res.cs_mask   = COL_FIELD_W'(cs);
    res.rs_mask   = ROW_FIELD_W'(rs);
    res.csrc_mask = COL_FIELD_W'(csrc);
    res.rsrc_mask = ROW_FIELD_W'(rsrc);
    return res;
  endfunction

  // response check first, so a word never matches a read taken at the same edge
  always @(posedge clk) begin
    line_masks_t want;
    if (rst) begin
      for (int c = 0; c < NUM_COLS; c++) key_down[c] = '0;
      resolved_q.delete();
      mismatches <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (resolved_q.size() == 0) begin
          $error("response word with no read outstanding");
          mismatches <= mismatches + 1;
        end else begin
          want = resolved_q.pop_front();
          if (rsp.col_sink_out !== want.cs_mask ||
              rsp.row_sink_out !== want.rs_mask ||
              rsp.col_source_out !== want.csrc_mask ||
              rsp.row_source_out !== want.rsrc_mask)
            mismatches <= mismatches + 1;
          if (rsp.col_sink_out !== want.cs_mask)
            $error("col_sink_out: expected %h, actual %h",
                   want.cs_mask, rsp.col_sink_out);
          if (rsp.row_sink_out !== want.rs_mask)
            $error("row_sink_out: expected %h, actual %h",
                   want.rs_mask, rsp.row_sink_out);
          if (rsp.col_source_out !== want.csrc_mask)
            $error("col_source_out: expected %h, actual %h",
                   want.csrc_mask, rsp.col_source_out);
          if (rsp.row_source_out !== want.rsrc_mask)
            $error("row_source_out: expected %h, actual %h",
                   want.rsrc_mask, rsp.row_source_out);
        end
      end
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_PRESS: begin
            if (req.key_col < NUM_COLS && req.key_row < NUM_ROWS)
              key_down[req.key_col][req.key_row] = 1'b1;
          end
          REQ_RELEASE: begin
            if (req.key_col < NUM_COLS && req.key_row < NUM_ROWS)
              key_down[req.key_col][req.key_row] = 1'b0;
          end
          REQ_READ: begin
            resolved_q.push_back(resolve_lines(req.col_sink_in, req.row_sink_in,
                                               req.col_source_in, req.row_source_in));
          end
          default: ;
        endcase
      end
    end
    pending <= resolved_q.size();
  end

endmodule

// ===== sim/key_matrix_ghost_resolver_test.sv =====
// ----------------------------------------------------------------------------
// key matrix ghost resolver test
// drives directed words, then press, release, read and unused-code words with
// random gaps and back-pressure in three phases; reports the checker's verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_matrix_ghost_resolver_test;
  import kmgr_pkg::*;

  localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;
  localparam int WORDS_PER_PHASE = 600;
  localparam int DRAIN_CYCLES    = 40;

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;

  kmgr_req_if req_bus ();
  kmgr_rsp_if rsp_bus ();

  key_matrix_ghost_resolver dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  key_matrix_ghost_resolver_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_bus),
    .rsp        (rsp_bus),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    rsp_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // one word on the request channel, with a random gap in front
  task automatic send_word(
    input logic [REQ_TYPE_W-1:0]  kind,
    input logic [KEY_COL_W-1:0]   col,
    input logic [KEY_ROW_W-1:0]   row,
    input logic [COL_FIELD_W-1:0] cs,
    input logic [ROW_FIELD_W-1:0] rs,
    input logic [COL_FIELD_W-1:0] csrc,
    input logic [ROW_FIELD_W-1:0] rsrc
  );
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid         <= 1'b1;
    req_bus.req_type      <= kind;
    req_bus.key_col       <= col;
    req_bus.key_row       <= row;
    req_bus.col_sink_in   <= cs;
    req_bus.row_sink_in   <= rs;
    req_bus.col_source_in <= csrc;
    req_bus.row_source_in <= rsrc;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
  endtask

  task automatic key_word(input logic [REQ_TYPE_W-1:0] kind,
                          input logic [KEY_COL_W-1:0] col,
                          input logic [KEY_ROW_W-1:0] row);
    send_word(kind, col, row, COL_FIELD_W'($urandom), ROW_FIELD_W'($urandom),
              COL_FIELD_W'($urandom), ROW_FIELD_W'($urandom));
  endtask

  task automatic read_word(input logic [COL_FIELD_W-1:0] cs,
                           input logic [ROW_FIELD_W-1:0] rs,
                           input logic [COL_FIELD_W-1:0] csrc,
                           input logic [ROW_FIELD_W-1:0] rsrc);
    send_word(REQ_READ, KEY_COL_W'($urandom), KEY_ROW_W'($urandom), cs, rs, csrc, rsrc);
  endtask

  // mostly scan-like reads and key changes, with some odd words mixed in
  task automatic random_word(input int press_pct);
    int sel;
    int mode;
    logic [KEY_ROW_W-1:0]   row;
    logic [COL_FIELD_W-1:0] cs;
    logic [ROW_FIELD_W-1:0] rs;
    logic [COL_FIELD_W-1:0] csrc;
    logic [ROW_FIELD_W-1:0] rsrc;
    sel = $urandom_range(0, 99);
    row = ($urandom_range(0, 15) == 0) ? KEY_ROW_W'(7) : KEY_ROW_W'($urandom_range(0, 6));
    if (sel < 5) begin
      send_word(REQ_UNUSED, KEY_COL_W'($urandom), KEY_ROW_W'($urandom),
                COL_FIELD_W'($urandom), ROW_FIELD_W'($urandom),
                COL_FIELD_W'($urandom), ROW_FIELD_W'($urandom));
    end else if (sel < 60) begin
      if ($urandom_range(0, 99) < press_pct)
        key_word(REQ_PRESS, KEY_COL_W'($urandom), row);
      else
        key_word(REQ_RELEASE, KEY_COL_W'($urandom), row);
    end else begin
      mode = $urandom_range(0, 3);
      cs   = '1;
      rs   = '1;
      case (mode)
        0: cs[3'($urandom_range(0, 7))] = 1'b0;
        1: rs[3'($urandom_range(0, 6))] = 1'b0;
        2: begin
          cs = COL_FIELD_W'($urandom);
          rs = ROW_FIELD_W'($urandom);
        end
        default: ;
      endcase
      csrc = ($urandom_range(0, 99) < 60) ? '0 : COL_FIELD_W'($urandom);
      rsrc = ($urandom_range(0, 99) < 60) ? '0 : ROW_FIELD_W'($urandom);
      read_word(cs, rs, csrc, rsrc);
    end
  endtask

  // stimulus and verdict
  initial begin
    int press_pct;
    rst                   = 1'b1;
    send_idle_pct         = 37;
    recv_stall_pct        = 63;
    req_bus.valid         = 1'b0;
    req_bus.req_type      = REQ_PRESS;
    req_bus.key_col       = '0;
    req_bus.key_row       = '0;
    req_bus.col_sink_in   = '1;
    req_bus.row_sink_in   = '1;
    req_bus.col_source_in = '0;
    req_bus.row_source_in = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty matrix passes masks through
    read_word(8'hFE, 7'h7F, 8'h00, 7'h00);
    read_word(8'h00, 7'h00, 8'hFF, 7'h7F);
    // corner keys, a row out of range and the unused code
    key_word(REQ_PRESS, 3'd0, 3'd0);
    key_word(REQ_PRESS, 3'd7, 3'd6);
    key_word(REQ_PRESS, 3'd3, 3'd7);
    send_word(REQ_UNUSED, 3'd7, 3'd7, 8'hFF, 7'h7F, 8'hFF, 7'h7F);
    read_word(8'hFE, 7'h7F, 8'h00, 7'h00);
    read_word(8'hFF, 7'h7F, 8'h80, 7'h00);
    read_word(8'hFF, 7'h7E, 8'h00, 7'h01);
    // ghost path: column 0 and column 7 share row 6
    key_word(REQ_PRESS, 3'd0, 3'd6);
    key_word(REQ_PRESS, 3'd7, 3'd3);
    read_word(8'h7F, 7'h7F, 8'h00, 7'h00);
    read_word(8'hFF, 7'h77, 8'h01, 7'h00);
    read_word(8'h00, 7'h00, 8'h00, 7'h00);
    read_word(8'hFF, 7'h7F, 8'hFF, 7'h7F);
    // releases, one out of range and one of a key not pressed
    key_word(REQ_RELEASE, 3'd0, 3'd0);
    key_word(REQ_RELEASE, 3'd7, 3'd7);
    key_word(REQ_RELEASE, 3'd4, 3'd2);
    read_word(8'hFE, 7'h7F, 8'h00, 7'h00);
    key_word(REQ_RELEASE, 3'd0, 3'd6);
    read_word(8'h7F, 7'h7F, 8'h80, 7'h40);

    // random phases: receiver stalls, then sender idles, then full rate
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 37;
          recv_stall_pct = 63;
        end
        1: begin
          send_idle_pct  = 63;
          recv_stall_pct = 37;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      press_pct = 50;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        // key density drifts so that both sparse and crowded matrices occur
        if (n % 64 == 0) begin
          case ($urandom_range(0, 2))
            0: press_pct = 20;
            1: press_pct = 50;
            default: press_pct = 80;
          endcase
        end
        random_word(press_pct);
      end
    end

    req_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
